@@ rtl/fsgs_pkg.sv @@
// ----------------------------------------------------------------------------
// Falling sand grid step package
// Grid sizes, particle record layout, probe direction codes and shared helpers.
// ----------------------------------------------------------------------------
package fsgs_pkg;

  // Grid geometry. Rows and columns are powers of two, so a cell address is
  // the row and column bits placed side by side.
  localparam int X_W        = 6;
  localparam int Y_W        = 6;
  localparam int GRID_W     = 2 ** X_W;
  localparam int GRID_H     = 2 ** Y_W;
  localparam int CELL_W     = X_W + Y_W;
  localparam int CELL_COUNT = 2 ** CELL_W;

  // Particle list sizes.
  localparam int IDX_W    = 12;
  localparam int MAX_PART = 2 ** IDX_W;
  localparam int CNT_W    = IDX_W + 1;

  // Particle kinds.
  localparam logic KIND_SAND  = 1'b0;
  localparam logic KIND_WATER = 1'b1;

  // Operation codes carried with each request.
  typedef enum logic [1:0] {
    OP_SPAWN = 2'd0,
    OP_TICK  = 2'd1,
    OP_READ  = 2'd2
  } op_e;

  // Probe directions, tried in this order.
  typedef enum logic [2:0] {
    ATT_DOWN       = 3'd0,
    ATT_DOWN_LEFT  = 3'd1,
    ATT_DOWN_RIGHT = 3'd2,
    ATT_LEFT       = 3'd3,
    ATT_RIGHT      = 3'd4
  } att_e;

  // One entry of the particle list.
  typedef struct packed {
    logic             settled;
    logic             kind;
    logic [Y_W-1:0]   y;
    logic [X_W-1:0]   x;
  } particle_t;

  // Candidate cell produced by the probe unit.
  typedef struct packed {
    logic              ok;
    logic [X_W-1:0]    x;
    logic [Y_W-1:0]    y;
    logic [CELL_W-1:0] addr;
  } cand_t;

  // Linear cell address: row times grid width plus column.
  function automatic logic [CELL_W-1:0] cell_of(input logic [X_W-1:0] x,
                                                input logic [Y_W-1:0] y);
    cell_of = {y, x};
  endfunction

endpackage

@@ rtl/fsgs_ram.sv @@
// ----------------------------------------------------------------------------
// Generic simple dual port RAM
// One write port and one read port with a registered read. No reset.
// ----------------------------------------------------------------------------
module fsgs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // Write and registered read; a read of the address being written sees the
  // old contents.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

@@ rtl/fsgs_cand.sv @@
// ----------------------------------------------------------------------------
// Falling sand probe unit
// Turns a particle position and a probe direction into a candidate cell,
// with a flag that says whether that cell lies on the grid.
// ----------------------------------------------------------------------------
module fsgs_cand (
  input  logic [fsgs_pkg::X_W-1:0] x_i,
  input  logic [fsgs_pkg::Y_W-1:0] y_i,
  input  fsgs_pkg::att_e           att_i,
  output fsgs_pkg::cand_t          cand_o
);

  logic [fsgs_pkg::X_W-1:0] nx;
  logic [fsgs_pkg::Y_W-1:0] ny;
  logic                     ok;
  logic                     at_left;
  logic                     at_right;

  assign at_left  = (x_i == '0);
  assign at_right = (x_i == fsgs_pkg::X_W'(fsgs_pkg::GRID_W - 1));

  // Neighbor selection. The caller only probes downward when the particle
  // is above the bottom row, so the row below is always on the grid.
  always_comb begin
    nx = x_i;
    ny = y_i;
    ok = 1'b1;
    case (att_i)
      fsgs_pkg::ATT_DOWN: begin
        ny = y_i + 1'b1;
      end
      fsgs_pkg::ATT_DOWN_LEFT: begin
        nx = x_i - 1'b1;
        ny = y_i + 1'b1;
        ok = !at_left;
      end
      fsgs_pkg::ATT_DOWN_RIGHT: begin
        nx = x_i + 1'b1;
        ny = y_i + 1'b1;
        ok = !at_right;
      end
      fsgs_pkg::ATT_LEFT: begin
        nx = x_i - 1'b1;
        ok = !at_left;
      end
      fsgs_pkg::ATT_RIGHT: begin
        nx = x_i + 1'b1;
        ok = !at_right;
      end
      default: begin
        ok = 1'b0;
      end
    endcase
  end

  assign cand_o.ok   = ok;
  assign cand_o.x    = nx;
  assign cand_o.y    = ny;
  assign cand_o.addr = fsgs_pkg::cell_of(nx, ny);

endmodule

@@ rtl/falling_sand_grid_step.sv @@
// ----------------------------------------------------------------------------
// Falling sand grid step
// Occupancy map and particle list with spawn, tick and read requests, run by
// a small sequencer around one probe unit and two single-port-pair memories.
// ----------------------------------------------------------------------------
// Usage:
//   A request enters on the s_axis channel: tuser carries the operation and
//   the particle kind, tdata the spawn cell and the read index. Each request
//   gives exactly one response on the m_axis channel: tuser is the accepted
//   flag, tdata the read particle and the particle count after the request.
//   Requests are handled one at a time; s_axis_tready is high only while the
//   sequencer is idle.
//   A tick walks the list in order, one occupancy memory read per probe;
//   it passes over a settled particle, settles one on the bottom row, and
//   otherwise probes the neighbors until it moves to a free one or settles.
//   After reset the occupancy map is cleared one cell a cycle, and no
//   request is taken until that pass ends.
//   The response waits in an output register; while the receiver stalls the
//   sequencer holds its finished response and takes no new request.
// ----------------------------------------------------------------------------
module falling_sand_grid_step (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Request channel.
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // tdata: cell_x [5:0], cell_y [11:6], index [23:12]
  input  logic [23:0] s_axis_tdata,
  // tuser: operation [1:0], kind [2]
  input  logic [2:0]  s_axis_tuser,
  // Response channel.
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // tdata: particle_x [5:0], particle_y [11:6], particle_kind [12],
  //        particle_settled [13], particle_count [26:14], zero [31:27]
  output logic [31:0] m_axis_tdata,
  // tuser: accepted [0]
  output logic        m_axis_tuser
);

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_SP_RD,
    S_SP_CHK,
    S_RD_RD,
    S_RD_CHK,
    S_TK_START,
    S_TK_LOAD,
    S_PR_RD,
    S_PR_CHK,
    S_MV_FREE,
    S_MV_SET,
    S_SETTLE,
    S_DONE
  } state_e;

  state_e                       state_q;
  logic [fsgs_pkg::CELL_W-1:0]  clr_q;
  logic [fsgs_pkg::CNT_W-1:0]   cnt_q;
  logic [fsgs_pkg::CNT_W-1:0]   i_q;
  logic                         kind_q;
  logic [fsgs_pkg::X_W-1:0]     cx_q;
  logic [fsgs_pkg::Y_W-1:0]     cy_q;
  logic [fsgs_pkg::IDX_W-1:0]   idx_q;
  fsgs_pkg::particle_t          cur_q;
  fsgs_pkg::att_e               att_q;
  logic                         res_acc_q;
  fsgs_pkg::particle_t          res_part_q;
  logic                         m_valid_q;
  logic [31:0]                  m_data_q;
  logic                         m_user_q;

  logic                         occ_we;
  logic [fsgs_pkg::CELL_W-1:0]  occ_waddr;
  logic                         occ_wdata;
  logic [fsgs_pkg::CELL_W-1:0]  occ_raddr;
  logic                         occ_rdata;
  logic                         st_we;
  logic [fsgs_pkg::IDX_W-1:0]   st_waddr;
  fsgs_pkg::particle_t          st_wdata;
  logic [fsgs_pkg::IDX_W-1:0]   st_raddr;
  fsgs_pkg::particle_t          st_rdata;
  fsgs_pkg::cand_t              cand;
  logic                         give_up;
  logic                         in_take;
  logic                         out_free;

  assign s_axis_tready = (state_q == S_IDLE);
  assign in_take       = s_axis_tvalid && s_axis_tready;
  assign out_free      = !m_valid_q || m_axis_tready;
  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;
  assign m_axis_tuser  = m_user_q;

  // Shared probe unit over the current particle and direction.
  fsgs_cand u_cand (
    .x_i    (cur_q.x),
    .y_i    (cur_q.y),
    .att_i  (att_q),
    .cand_o (cand)
  );

  // Occupancy map, one bit per cell.
  fsgs_ram #(
    .WIDTH (1),
    .DEPTH (fsgs_pkg::CELL_COUNT)
  ) u_occ (
    .clk_i   (clk_i),
    .we_i    (occ_we),
    .waddr_i (occ_waddr),
    .wdata_i (occ_wdata),
    .raddr_i (occ_raddr),
    .rdata_o (occ_rdata)
  );

  // Particle list in spawn order.
  fsgs_ram #(
    .WIDTH ($bits(fsgs_pkg::particle_t)),
    .DEPTH (fsgs_pkg::MAX_PART)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (st_we),
    .waddr_i (st_waddr),
    .wdata_i (st_wdata),
    .raddr_i (st_raddr),
    .rdata_o (st_rdata)
  );

  // Sand stops after the three downward probes, water after all five.
  assign give_up = ((att_q == fsgs_pkg::ATT_DOWN_RIGHT) && (cur_q.kind == fsgs_pkg::KIND_SAND))
                   || (att_q == fsgs_pkg::ATT_RIGHT);

  // Memory port steering.
  always_comb begin
    occ_we    = 1'b0;
    occ_waddr = cand.addr;
    occ_wdata = 1'b1;
    occ_raddr = cand.addr;
    st_we     = 1'b0;
    st_waddr  = i_q[fsgs_pkg::IDX_W-1:0];
    st_wdata  = cur_q;
    st_raddr  = i_q[fsgs_pkg::IDX_W-1:0];
    case (state_q)
      S_CLEAR: begin
        occ_we    = 1'b1;
        occ_waddr = clr_q;
        occ_wdata = 1'b0;
      end
      S_SP_RD: begin
        occ_raddr = fsgs_pkg::cell_of(cx_q, cy_q);
      end
      S_SP_CHK: begin
        occ_we           = !occ_rdata;
        occ_waddr        = fsgs_pkg::cell_of(cx_q, cy_q);
        st_we            = !occ_rdata;
        st_waddr         = cnt_q[fsgs_pkg::IDX_W-1:0];
        st_wdata.x       = cx_q;
        st_wdata.y       = cy_q;
        st_wdata.kind    = kind_q;
        st_wdata.settled = 1'b0;
      end
      S_RD_RD: begin
        st_raddr = idx_q;
      end
      S_MV_FREE: begin
        occ_we    = 1'b1;
        occ_waddr = fsgs_pkg::cell_of(cur_q.x, cur_q.y);
        occ_wdata = 1'b0;
      end
      S_MV_SET: begin
        occ_we     = 1'b1;
        st_we      = 1'b1;
        st_wdata.x = cand.x;
        st_wdata.y = cand.y;
      end
      S_SETTLE: begin
        st_we            = 1'b1;
        st_wdata.settled = 1'b1;
      end
      default: begin
      end
    endcase
  end

  // Sequencer and response register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_CLEAR;
      clr_q      <= '0;
      cnt_q      <= '0;
      i_q        <= '0;
      kind_q     <= 1'b0;
      cx_q       <= '0;
      cy_q       <= '0;
      idx_q      <= '0;
      cur_q      <= '0;
      att_q      <= fsgs_pkg::ATT_DOWN;
      res_acc_q  <= 1'b0;
      res_part_q <= '0;
      m_valid_q  <= 1'b0;
      m_data_q   <= '0;
      m_user_q   <= 1'b0;
    end else begin
      // The finished response is loaded in S_DONE; elsewhere a taken one drops.
      if (m_valid_q && m_axis_tready && (state_q != S_DONE)) begin
        m_valid_q <= 1'b0;
      end
      case (state_q)
        S_CLEAR: begin
          clr_q <= clr_q + 1'b1;
          if (clr_q == '1) begin
            state_q <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (in_take) begin
            kind_q     <= s_axis_tuser[2];
            cx_q       <= s_axis_tdata[5:0];
            cy_q       <= s_axis_tdata[11:6];
            idx_q      <= s_axis_tdata[23:12];
            res_acc_q  <= 1'b0;
            res_part_q <= '0;
            i_q        <= '0;
            case (fsgs_pkg::op_e'(s_axis_tuser[1:0]))
              fsgs_pkg::OP_SPAWN: state_q <= S_SP_RD;
              fsgs_pkg::OP_TICK:  state_q <= S_TK_START;
              fsgs_pkg::OP_READ:  state_q <= S_RD_RD;
              default:            state_q <= S_DONE;
            endcase
          end
        end
        // Spawn: check room in the list, then the target cell.
        S_SP_RD: begin
          if (cnt_q != fsgs_pkg::CNT_W'(fsgs_pkg::MAX_PART)) begin
            state_q <= S_SP_CHK;
          end else begin
            state_q <= S_DONE;
          end
        end
        S_SP_CHK: begin
          if (!occ_rdata) begin
            cnt_q     <= cnt_q + 1'b1;
            res_acc_q <= 1'b1;
          end
          state_q <= S_DONE;
        end
        // Read one list entry.
        S_RD_RD: begin
          if ({1'b0, idx_q} < cnt_q) begin
            state_q <= S_RD_CHK;
          end else begin
            state_q <= S_DONE;
          end
        end
        S_RD_CHK: begin
          res_acc_q  <= 1'b1;
          res_part_q <= st_rdata;
          state_q    <= S_DONE;
        end
        // Tick: walk the list in order.
        S_TK_START: begin
          if (i_q < cnt_q) begin
            state_q <= S_TK_LOAD;
          end else begin
            state_q <= S_DONE;
          end
        end
        S_TK_LOAD: begin
          cur_q <= st_rdata;
          att_q <= fsgs_pkg::ATT_DOWN;
          if (st_rdata.settled) begin
            i_q     <= i_q + 1'b1;
            state_q <= S_TK_START;
          end else if (st_rdata.y == fsgs_pkg::Y_W'(fsgs_pkg::GRID_H - 1)) begin
            state_q <= S_SETTLE;
          end else begin
            state_q <= S_PR_RD;
          end
        end
        // Probe the next neighbor; off-grid neighbors are skipped.
        S_PR_RD: begin
          if (cand.ok) begin
            state_q <= S_PR_CHK;
          end else if (give_up) begin
            state_q <= S_SETTLE;
          end else begin
            att_q <= fsgs_pkg::att_e'(att_q + 3'd1);
          end
        end
        S_PR_CHK: begin
          if (!occ_rdata) begin
            state_q <= S_MV_FREE;
          end else if (give_up) begin
            state_q <= S_SETTLE;
          end else begin
            att_q   <= fsgs_pkg::att_e'(att_q + 3'd1);
            state_q <= S_PR_RD;
          end
        end
        S_MV_FREE: begin
          state_q <= S_MV_SET;
        end
        S_MV_SET: begin
          i_q     <= i_q + 1'b1;
          state_q <= S_TK_START;
        end
        S_SETTLE: begin
          i_q     <= i_q + 1'b1;
          state_q <= S_TK_START;
        end
        // Hand the response to the output register once it is free.
        S_DONE: begin
          if (out_free) begin
            m_valid_q <= 1'b1;
            m_user_q  <= res_acc_q;
            m_data_q  <= {5'd0, cnt_q, res_part_q.settled, res_part_q.kind,
                          res_part_q.y, res_part_q.x};
            state_q   <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

`ifndef ASSERT_OFF
  // The list never holds more than its capacity.
  a_cnt_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= fsgs_pkg::CNT_W'(fsgs_pkg::MAX_PART))
    else $error("particle count above capacity");

  // The count only ever grows by one, on an accepted spawn.
  a_cnt_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q != $past(cnt_q)) |-> ((cnt_q == $past(cnt_q) + 1'b1)
                                 && ($past(state_q) == S_SP_CHK)))
    else $error("particle count changed outside a spawn");

  // No request is taken during the clearing pass.
  a_clear_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_CLEAR) |-> !s_axis_tready)
    else $error("request taken while clearing the map");

  // A probe that finds its cell empty is followed by a move.
  a_move_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_PR_CHK) && !occ_rdata |=> (state_q == S_MV_FREE))
    else $error("move did not follow a free probe");

  // A response is never loaded over one that the receiver has not taken.
  a_no_overrun: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DONE) && m_valid_q && !m_axis_tready |=> (state_q == S_DONE))
    else $error("response overwritten while stalled");
`endif

endmodule
